@@ src/psf_pkg.sv @@
package psf_pkg;

    // Default geometry of the slot store.
    localparam int SLOT_BYTES_DEF = 64;
    localparam int SLOT_COUNT_DEF = 16;

    // Fixed widths of the result fields.
    localparam int STATUS_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int LENGTH_W  = 7;
    localparam int WAITING_W = 5;

    // Operation codes of an input item.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_POP   = 3'b100
    } t_state;

endpackage

@@ src/packet_slot_fifo.sv @@
// Push: one byte per cycle when not busy; its result strobes the next cycle, busy stays low.
// Pop: busy while the byte memory streams the tail slot one byte per cycle; results
// strobe from the registered read port after the pop state. An empty pop answers in the
// next cycle. Results cannot be stalled by the receiver.
// Reset (synchronous) clears the counters, then a clearing pass zeroes every address of
// the byte memory with busy high.
module packet_slot_fifo #(
    parameter int SLOT_BYTES = psf_pkg::SLOT_BYTES_DEF,
    parameter int SLOT_COUNT = psf_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_operation,
    input  logic [psf_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_strobe,
    output logic [psf_pkg::STATUS_W-1:0]   o_status,
    output logic [psf_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_out_last,
    output logic [psf_pkg::LENGTH_W-1:0]   o_packet_length,
    output logic [psf_pkg::WAITING_W-1:0]  o_packets_waiting,
    output logic [psf_pkg::WAITING_W-1:0]  o_peak_waiting,
    output logic                           o_not_empty
);

    localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int OW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int LW    = $clog2(SLOT_BYTES + 1);
    localparam int CW    = $clog2(SLOT_COUNT + 1);

    psf_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_peak, n_peak;
    logic [LW-1:0] r_wr_off, n_wr_off;
    logic          r_in_prog, n_in_prog;
    logic          r_dropping, n_dropping;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [SW-1:0] r_pop_slot, n_pop_slot;
    logic [OW-1:0] r_rd_off, n_rd_off;

    // Registered result.
    logic                  r_res_valid, n_res_valid;
    psf_pkg::t_status      r_res_status, n_res_status;
    logic                  r_res_last, n_res_last;
    logic [LW-1:0]         r_res_len, n_res_len;
    logic                  r_res_from_ram, n_res_from_ram;

    // Memory ports.
    logic                       byte_we;
    logic [AW-1:0]              byte_waddr;
    logic [psf_pkg::BYTE_W-1:0] byte_wdata;
    logic [AW-1:0]              byte_raddr;
    logic [psf_pkg::BYTE_W-1:0] byte_rdata;
    logic                       len_we;
    logic [LW-1:0]              len_rdata;

    logic          take;
    logic          eff_drop;
    logic [LW-1:0] eff_off;

    assign busy = (r_state != psf_pkg::S_IDLE);
    assign take = start && !busy;

    // State of the open packet as seen by this byte.
    assign eff_drop = r_in_prog ? r_dropping : (r_count >= CW'(SLOT_COUNT));
    assign eff_off  = r_in_prog ? r_wr_off : '0;

    assign byte_raddr = AW'(r_pop_slot) * AW'(SLOT_BYTES) + AW'(r_rd_off);

    // Next-state logic for pushes, pops and the clearing pass.
    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_peak         = r_peak;
        n_wr_off       = r_wr_off;
        n_in_prog      = r_in_prog;
        n_dropping     = r_dropping;
        n_clr_addr     = r_clr_addr;
        n_pop_slot     = r_pop_slot;
        n_rd_off       = r_rd_off;
        n_res_valid    = 1'b0;
        n_res_status   = psf_pkg::ST_OK;
        n_res_last     = 1'b1;
        n_res_len      = '0;
        n_res_from_ram = 1'b0;
        byte_we        = 1'b0;
        byte_waddr     = AW'(r_head) * AW'(SLOT_BYTES) + AW'(eff_off);
        byte_wdata     = i_data_byte;
        len_we         = 1'b0;

        unique case (r_state)
            psf_pkg::S_CLEAR: begin
                byte_we    = 1'b1;
                byte_waddr = r_clr_addr;
                byte_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = psf_pkg::S_IDLE;
                end
            end

            psf_pkg::S_IDLE: begin
                if (take && i_operation == psf_pkg::OP_PUSH) begin
                    n_res_valid = 1'b1;
                    n_wr_off    = eff_off;
                    if (eff_drop) begin
                        n_res_status = psf_pkg::ST_FULL;
                        n_res_len    = '0;
                    end else if (eff_off < LW'(SLOT_BYTES)) begin
                        byte_we      = 1'b1;
                        n_wr_off     = eff_off + 1'b1;
                        n_res_status = psf_pkg::ST_OK;
                        n_res_len    = eff_off + 1'b1;
                    end else begin
                        n_res_status = psf_pkg::ST_OVERSIZE;
                        n_res_len    = eff_off;
                    end
                    if (i_last_byte) begin
                        // Close the packet.
                        if (!eff_drop) begin
                            len_we = 1'b1;
                            n_head = (r_head == SW'(SLOT_COUNT - 1)) ? '0 : r_head + 1'b1;
                            n_count = r_count + 1'b1;
                            if (r_count + 1'b1 > r_peak) begin
                                n_peak = r_count + 1'b1;
                            end
                        end
                        n_in_prog  = 1'b0;
                        n_dropping = 1'b0;
                        n_wr_off   = '0;
                    end else begin
                        n_in_prog  = 1'b1;
                        n_dropping = eff_drop;
                    end
                end else if (take) begin
                    if (r_count == '0) begin
                        n_res_valid  = 1'b1;
                        n_res_status = psf_pkg::ST_EMPTY;
                    end else begin
                        n_pop_slot = r_tail;
                        n_rd_off   = '0;
                        n_tail     = (r_tail == SW'(SLOT_COUNT - 1)) ? '0 : r_tail + 1'b1;
                        n_count    = r_count - 1'b1;
                        n_state    = psf_pkg::S_POP;
                    end
                end
            end

            psf_pkg::S_POP: begin
                // Each cycle reads one byte; it shows on the ports in the next cycle.
                n_res_valid    = 1'b1;
                n_res_from_ram = 1'b1;
                n_res_last     = (r_rd_off == OW'(SLOT_BYTES - 1));
                n_rd_off       = r_rd_off + 1'b1;
                if (r_rd_off == OW'(SLOT_BYTES - 1)) begin
                    n_state = psf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = psf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psf_pkg::S_CLEAR;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_wr_off    <= '0;
            r_in_prog   <= 1'b0;
            r_dropping  <= 1'b0;
            r_clr_addr  <= '0;
            r_rd_off    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_peak      <= n_peak;
            r_wr_off    <= n_wr_off;
            r_in_prog   <= n_in_prog;
            r_dropping  <= n_dropping;
            r_clr_addr  <= n_clr_addr;
            r_rd_off    <= n_rd_off;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pop_slot     <= n_pop_slot;
        r_res_status   <= n_res_status;
        r_res_last     <= n_res_last;
        r_res_len      <= n_res_len;
        r_res_from_ram <= n_res_from_ram;
    end

    // Byte store.
    psf_ram #(
        .WIDTH(psf_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_byte_ram (
        .i_clk  (i_clk),
        .i_we   (byte_we),
        .i_waddr(byte_waddr),
        .i_wdata(byte_wdata),
        .i_raddr(byte_raddr),
        .o_rdata(byte_rdata)
    );

    // Stored packet lengths, one entry per slot.
    psf_ram #(
        .WIDTH(LW),
        .DEPTH(SLOT_COUNT)
    ) u_len_ram (
        .i_clk  (i_clk),
        .i_we   (len_we),
        .i_waddr(r_head),
        .i_wdata(n_wr_off == '0 ? eff_off + LW'(!eff_drop && eff_off < LW'(SLOT_BYTES))
                                : n_wr_off),
        .i_raddr(r_pop_slot),
        .o_rdata(len_rdata)
    );

    // Result ports.
    assign o_strobe          = r_res_valid;
    assign o_status          = r_res_status;
    assign o_out_byte        = r_res_from_ram ? byte_rdata : '0;
    assign o_out_last        = r_res_last;
    assign o_packet_length   = psf_pkg::LENGTH_W'(r_res_from_ram ? len_rdata : r_res_len);
    assign o_packets_waiting = psf_pkg::WAITING_W'(r_count);
    assign o_peak_waiting    = psf_pkg::WAITING_W'(r_peak);
    assign o_not_empty       = (r_count != '0);

    // No result leaves the block during the clearing pass.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psf_pkg::S_CLEAR) |-> !r_res_valid)
        else $error("result strobe during clearing pass");

    // The packet count stays within the slot count and at or below the peak.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(SLOT_COUNT)) && (r_peak >= r_count))
        else $error("packet count out of range");

    // A pop of a non-empty FIFO starts a stream and takes one packet off.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_operation == psf_pkg::OP_POP && r_count != '0)
        |=> (r_state == psf_pkg::S_POP) && (r_count == $past(r_count) - 1'b1))
        else $error("pop did not start a stream");

    // A stream ends with the last mark as it returns to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psf_pkg::S_POP && r_rd_off == OW'(SLOT_BYTES - 1))
        |=> (r_res_valid && r_res_last && r_state == psf_pkg::S_IDLE))
        else $error("pop stream ended without last mark");

endmodule

@@ src/psf_ram.sv @@
module psf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
